// File: rtl/x64enc_pkg.sv
// ----------------------------------------------------------------------------
// x64enc_pkg
// Shared types and codes for the x86-64 instruction encoder.
// ----------------------------------------------------------------------------
package x64enc_pkg;

  localparam logic [3:0] ACT_XOR     = 4'd0;
  localparam logic [3:0] ACT_MOV_RR  = 4'd1;
  localparam logic [3:0] ACT_MOV_IMM = 4'd2;
  localparam logic [3:0] ACT_MOVZX   = 4'd3;
  localparam logic [3:0] ACT_ADD_IMM = 4'd4;
  localparam logic [3:0] ACT_SUB_IMM = 4'd5;
  localparam logic [3:0] ACT_ADD_RR  = 4'd6;
  localparam logic [3:0] ACT_SUB_RR  = 4'd7;
  localparam logic [3:0] ACT_MUL     = 4'd8;
  localparam logic [3:0] ACT_STORE   = 4'd9;
  localparam logic [3:0] ACT_LOAD    = 4'd10;

  localparam logic [1:0] SZ_1 = 2'd0;
  localparam logic [1:0] SZ_2 = 2'd1;
  localparam logic [1:0] SZ_4 = 2'd2;
  localparam logic [1:0] SZ_8 = 2'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_SIZE = 2'd1;
  localparam logic [1:0] ERR_ADDR = 2'd2;

  localparam logic [7:0] PFX_OPSIZE = 8'h66;
  localparam logic [7:0] PFX_REXW   = 8'h48;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // one classified instruction: leading bytes (first byte in bits 7:0),
  // then n_imm literal bytes, low byte first
  typedef struct packed {
    logic [31:0] head;
    logic [2:0]  n_head;
    logic [3:0]  n_imm;
    logic [63:0] lit;
    logic [1:0]  err;
  } desc_t;

endpackage

// File: rtl/x64_instruction_encoder_unit.sv
// ----------------------------------------------------------------------------
// x64_instruction_encoder_unit
// x86-64 instruction encoder: one request in, its machine code bytes out.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | start / busy       | in_action, in_size_code, in_to_size_code,
//            |                    | in_reg_field, in_rm_field, in_literal
//  result    | out_strobe         | out_code_byte, out_last_byte, out_error_code
//
//  Each instruction yields 1 to 10 result words, one per cycle; the back end
//  serialiser sets the rate, and an instruction that is already queued
//  follows the last byte of the one before with no gap between them.
//  A taken request is queued, then loaded by the back end, then registered out.
//  A two-entry queue decouples the front from the back; busy is high only
//  while that queue is full.
//  Reset (rst_n low, synchronous) empties the queue and drops any word in
//  flight. The receiver cannot stall: every strobed word is taken.
//
module x64_instruction_encoder_unit import x64enc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_action,
  input  logic [1:0]  in_size_code,
  input  logic [1:0]  in_to_size_code,
  input  logic [2:0]  in_reg_field,
  input  logic [2:0]  in_rm_field,
  input  logic [63:0] in_literal,
  output logic        out_strobe,
  output logic [7:0]  out_code_byte,
  output logic        out_last_byte,
  output logic [1:0]  out_error_code
);

  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_not_empty;
  desc_t push_desc;
  desc_t head_desc;

  // classify the request and push it when the queue has room
  x64enc_front u_front (
    .start           (start),
    .q_full          (q_full),
    .in_action       (in_action),
    .in_size_code    (in_size_code),
    .in_to_size_code (in_to_size_code),
    .in_reg_field    (in_reg_field),
    .in_rm_field     (in_rm_field),
    .in_literal      (in_literal),
    .busy            (busy),
    .push            (push),
    .desc            (push_desc)
  );

  // hold classified instructions until the serialiser is ready
  x64enc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // emit the bytes, header first then the immediate low byte first
  x64enc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_desc         (head_desc),
    .pop            (pop),
    .out_strobe     (out_strobe),
    .out_code_byte  (out_code_byte),
    .out_last_byte  (out_last_byte),
    .out_error_code (out_error_code)
  );

endmodule

// File: rtl/x64enc_front.sv
// ----------------------------------------------------------------------------
// x64enc_front
// Accepts requests and classifies them into header bytes, immediate length
// and error code.
// ----------------------------------------------------------------------------
module x64enc_front import x64enc_pkg::*; (
  input  logic        start,
  input  logic        q_full,
  input  logic [3:0]  in_action,
  input  logic [1:0]  in_size_code,
  input  logic [1:0]  in_to_size_code,
  input  logic [2:0]  in_reg_field,
  input  logic [2:0]  in_rm_field,
  input  logic [63:0] in_literal,
  output logic        busy,
  output logic        push,
  output desc_t       desc
);

  // optional prefix followed by nbody body bytes
  function automatic desc_t pack(input logic has_pre, input logic [7:0] pre,
                                 input logic [7:0] b1, input logic [7:0] b2,
                                 input logic [7:0] b3, input logic [1:0] nbody);
    desc_t d;
    d = '0;
    if (has_pre) begin
      d.head   = {b3, b2, b1, pre};
      d.n_head = {1'b0, nbody} + 3'd1;
    end else begin
      d.head   = {8'h00, b3, b2, b1};
      d.n_head = {1'b0, nbody};
    end
    return d;
  endfunction

  logic       sz_pre;
  logic [7:0] sz_pfx;
  logic       zx_pre;
  logic [7:0] zx_pfx;
  logic [7:0] mr_rr;
  logic [7:0] mr_self;
  logic [7:0] mr_mem;
  logic [3:0] imm_len;
  logic       is_byte;
  desc_t      d;

  assign busy = q_full;
  assign push = start & ~q_full;

  always_comb begin
    sz_pre  = (in_size_code == SZ_2) || (in_size_code == SZ_8);
    sz_pfx  = (in_size_code == SZ_2) ? PFX_OPSIZE : PFX_REXW;
    zx_pre  = (in_to_size_code == SZ_2) || (in_to_size_code == SZ_8);
    zx_pfx  = (in_to_size_code == SZ_2) ? PFX_OPSIZE : PFX_REXW;
    mr_rr   = {2'b11, in_reg_field, in_rm_field};
    mr_self = {2'b11, in_rm_field, in_rm_field};
    mr_mem  = {2'b00, in_reg_field, in_rm_field};
    imm_len = 4'd1 << in_size_code;
    is_byte = (in_size_code == SZ_1);
    d       = '0;
    d.n_head = 3'd1;
    d.err    = ERR_SIZE;
    case (in_action)
      ACT_XOR: begin
        d = pack(sz_pre, sz_pfx, is_byte ? 8'h32 : 8'h33, mr_self, 8'h00, 2'd2);
      end
      ACT_MOV_RR: begin
        d = pack(sz_pre, sz_pfx, is_byte ? 8'h88 : 8'h89, mr_rr, 8'h00, 2'd2);
      end
      ACT_MOV_IMM: begin
        d = pack(sz_pre, sz_pfx, {is_byte ? 5'b10110 : 5'b10111, in_rm_field},
                 8'h00, 8'h00, 2'd1);
        d.n_imm = imm_len;
      end
      ACT_MOVZX: begin
        if (in_size_code == SZ_1 && in_to_size_code != SZ_1) begin
          d = pack(zx_pre, zx_pfx, 8'h0f, 8'hb6, mr_self, 2'd3);
        end else if (in_size_code == SZ_2 &&
                     (in_to_size_code == SZ_4 || in_to_size_code == SZ_8)) begin
          d = pack(zx_pre, zx_pfx, 8'h0f, 8'hb7, mr_self, 2'd3);
        end
      end
      ACT_ADD_IMM, ACT_SUB_IMM: begin
        if (in_size_code != SZ_8) begin
          d = pack(sz_pre, sz_pfx, is_byte ? 8'h80 : 8'h81,
                   {(in_action == ACT_ADD_IMM) ? 5'b11000 : 5'b11101, in_rm_field},
                   8'h00, 2'd2);
          d.n_imm = imm_len;
        end
      end
      ACT_ADD_RR: begin
        d = pack(sz_pre, sz_pfx, is_byte ? 8'h00 : 8'h01, mr_rr, 8'h00, 2'd2);
      end
      ACT_SUB_RR: begin
        d = pack(sz_pre, sz_pfx, is_byte ? 8'h28 : 8'h29, mr_rr, 8'h00, 2'd2);
      end
      ACT_MUL: begin
        d = pack(sz_pre, sz_pfx, is_byte ? 8'hf6 : 8'hf7,
                 {5'b11100, in_rm_field}, 8'h00, 2'd2);
      end
      ACT_STORE, ACT_LOAD: begin
        if (in_rm_field[2]) begin
          d.err = ERR_ADDR;
        end else if (in_action == ACT_STORE) begin
          d = pack(sz_pre, sz_pfx, is_byte ? 8'h88 : 8'h89, mr_mem, 8'h00, 2'd2);
        end else begin
          d = pack(sz_pre, sz_pfx, is_byte ? 8'h8a : 8'h8b, mr_mem, 8'h00, 2'd2);
        end
      end
      default: begin
        d.err = ERR_SIZE;
      end
    endcase
    d.lit = in_literal;
    desc  = d;
  end

endmodule

// File: rtl/x64enc_queue.sv
// ----------------------------------------------------------------------------
// x64enc_queue
// Two-entry queue of classified instructions between front and back.
// ----------------------------------------------------------------------------
module x64enc_queue import x64enc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head_desc,
  output logic  not_empty,
  output logic  full
);

  desc_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign head_desc = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// File: rtl/x64enc_back.sv
// ----------------------------------------------------------------------------
// x64enc_back
// Serialises a classified instruction, one code byte per cycle.
// ----------------------------------------------------------------------------
module x64enc_back import x64enc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  desc_t      q_desc,
  output logic       pop,
  output logic       out_strobe,
  output logic [7:0] out_code_byte,
  output logic       out_last_byte,
  output logic [1:0] out_error_code
);

  logic        active_r, active_nxt;
  logic [31:0] head_r, head_nxt;
  logic [2:0]  hcnt_r, hcnt_nxt;
  logic [63:0] lit_r, lit_nxt;
  logic [3:0]  icnt_r, icnt_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        strobe_r;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  errc_r;

  always_comb begin
    head_nxt = head_r;
    hcnt_nxt = hcnt_r;
    lit_nxt  = lit_r;
    icnt_nxt = icnt_r;
    err_nxt  = err_r;
    byte_nxt = head_r[7:0];
    last_nxt = 1'b0;
    // emit the current byte and advance
    if (active_r) begin
      if (hcnt_r != 3'd0) begin
        byte_nxt = head_r[7:0];
        head_nxt = {8'h00, head_r[31:8]};
        hcnt_nxt = hcnt_r - 3'd1;
        last_nxt = (hcnt_r == 3'd1) && (icnt_r == 4'd0);
      end else begin
        byte_nxt = lit_r[7:0];
        lit_nxt  = {8'h00, lit_r[63:8]};
        icnt_nxt = icnt_r - 4'd1;
        last_nxt = (icnt_r == 4'd1);
      end
    end
    // take the next instruction when idle or in the cycle the last byte is selected
    pop        = q_not_empty && (!active_r || last_nxt);
    active_nxt = pop || (active_r && !last_nxt);
    if (pop) begin
      head_nxt = q_desc.head;
      hcnt_nxt = q_desc.n_head;
      lit_nxt  = q_desc.lit;
      icnt_nxt = q_desc.n_imm;
      err_nxt  = q_desc.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      strobe_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    hcnt_r <= hcnt_nxt;
    lit_r  <= lit_nxt;
    icnt_r <= icnt_nxt;
    err_r  <= err_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    errc_r <= err_r;
  end

  assign out_strobe     = strobe_r;
  assign out_code_byte  = byte_r;
  assign out_last_byte  = last_r;
  assign out_error_code = errc_r;

endmodule

// File: rtl/x64enc_checker.sv
// ----------------------------------------------------------------------------
// x64enc_checker
// Port-level checks for the instruction encoder, bound to the top level.
// ----------------------------------------------------------------------------
module x64enc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [7:0] out_code_byte,
  input logic       out_last_byte,
  input logic [1:0] out_error_code
);

  // reset empties the queue and silences the output
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe && !busy)
    else $error("output or busy active after reset");

  // an error is a single zero word closing the instruction
  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_error_code != 2'd0 |-> out_last_byte && out_code_byte == 8'h00)
    else $error("malformed error word");

  // the bytes of one instruction leave without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_byte |=> out_strobe)
    else $error("gap inside an instruction");

  // the queue can only fill through an accepted request
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !busy ##1 busy |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind x64_instruction_encoder_unit x64enc_checker u_chk (.*);
